// ===== sv/ipv4_tcp_header_builder_macros.svh =====
`ifndef IPV4_TCP_HEADER_BUILDER_MACROS_SVH
`define IPV4_TCP_HEADER_BUILDER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ITHB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ITHB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ithb_pkg.sv =====
package ithb_pkg;

  localparam int unsigned HdrWords  = 10;
  localparam int unsigned WordIdxW  = 4;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [WordIdxW-1:0] LastIdx = WordIdxW'(HdrWords - 1);

  localparam logic [7:0]  IpVerIhl   = 8'h45;
  localparam logic [7:0]  IpTtl      = 8'd250;
  localparam logic [7:0]  IpProtoTcp = 8'd6;
  localparam logic [3:0]  TcpOffset  = 4'd5;
  localparam logic [15:0] TcpWindow  = 16'd32120;
  localparam logic [15:0] TcpHdrLen  = 16'd20;
  localparam logic [15:0] HdrBytes   = 16'd40;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcAddr  = 4'd0,
    CfgDstAddr  = 4'd1,
    CfgSrcPort  = 4'd2,
    CfgDstPort  = 4'd3,
    CfgStartSeq = 4'd4,
    CfgAckNum   = 4'd5,
    CfgFlags    = 4'd6,
    CfgUseAnn   = 4'd7
  } cfg_reg_e;

  typedef logic [31:0] word_t;

  // end-around carry fold and complement
  function automatic logic [15:0] csum_fold(input logic [19:0] acc);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = 17'(acc[15:0]) + 17'(acc[19:16]);
    s2 = s1[15:0] + 16'(s1[16]);
    return ~s2;
  endfunction

endpackage

// ===== sv/ithb_if.sv =====
interface ithb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_length;
  logic [31:0] annotated_dest;

  modport source (output valid, output payload_length, output annotated_dest, input ready);
  modport sink (input valid, input payload_length, input annotated_dest, output ready);
endinterface

interface ithb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic [3:0]  word_index;
  logic        last_word;

  modport source (output valid, output header_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input header_word, input word_index, input last_word,
                output ready);
endinterface

interface ithb_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/ipv4_tcp_header_builder.sv =====
// Builds a 40-byte IPv4 + TCP header for each packet transaction on in_i and
// streams it on out_o as ten 32-bit big-endian words, word_index 0..9, with
// last_word on word 9. The output channel moves one word per cycle while
// out_o.ready is high; the next packet is taken into an input register while
// the current header streams, and its header is computed and loaded in the
// cycle the last word leaves. An accepted packet goes into the input register
// and from there into the word registers. The IP identification starts
// at 0 and counts packets; the TCP sequence starts at start_sequence (loaded
// on each write of it) and advances by payload_length per packet. The cfg_i
// port is always ready; write it only while no packet is in flight.
module ipv4_tcp_header_builder
  import ithb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ithb_cfg_if.sink   cfg_i,
  ithb_in_if.sink    in_i,
  ithb_out_if.source out_o
);

`include "ipv4_tcp_header_builder_macros.svh"

  logic [31:0] src_addr_q, dst_addr_q, ack_q;
  logic [15:0] src_port_q, dst_port_q;
  logic [7:0]  flags_q;
  logic        use_ann_q;

  logic [15:0] ident_q;
  logic [31:0] seq_q;

  logic        in_valid_q;
  logic [15:0] len_q;
  logic [31:0] ann_q;

  logic                busy_q;
  logic [WordIdxW-1:0] cnt_q;
  word_t               words_q [HdrWords];

  logic        load;
  logic        out_hs;
  logic        out_last;
  logic [31:0] dst;
  logic [15:0] total;
  logic [19:0] ip_acc, tcp_acc;
  logic [15:0] ip_csum, tcp_csum;
  word_t       words_d [HdrWords];

  assign cfg_i.ready = 1'b1;

  assign out_last = (cnt_q == LastIdx);
  assign out_hs   = busy_q && out_o.ready;
  assign load     = in_valid_q && (!busy_q || (out_hs && out_last));
  assign in_i.ready = !in_valid_q || load;

  assign out_o.valid       = busy_q;
  assign out_o.header_word = words_q[0];
  assign out_o.word_index  = cnt_q;
  assign out_o.last_word   = out_last;

  always_comb begin
    dst   = use_ann_q ? ann_q : dst_addr_q;
    total = len_q + HdrBytes;

    ip_acc = 20'({IpVerIhl, 8'h00}) + 20'(total) + 20'(ident_q)
           + 20'({IpTtl, IpProtoTcp})
           + 20'(src_addr_q[31:16]) + 20'(src_addr_q[15:0])
           + 20'(dst[31:16]) + 20'(dst[15:0]);
    ip_csum = csum_fold(ip_acc);

    tcp_acc = 20'(src_port_q) + 20'(dst_port_q)
            + 20'(seq_q[31:16]) + 20'(seq_q[15:0])
            + 20'(ack_q[31:16]) + 20'(ack_q[15:0])
            + 20'({TcpOffset, 4'h0, flags_q}) + 20'(TcpWindow)
            + 20'(src_addr_q[31:16]) + 20'(src_addr_q[15:0])
            + 20'(dst[31:16]) + 20'(dst[15:0])
            + 20'(IpProtoTcp) + 20'(TcpHdrLen);
    tcp_csum = csum_fold(tcp_acc);

    words_d[0] = {IpVerIhl, 8'h00, total};
    words_d[1] = {ident_q, 16'h0000};
    words_d[2] = {IpTtl, IpProtoTcp, ip_csum};
    words_d[3] = src_addr_q;
    words_d[4] = dst;
    words_d[5] = {src_port_q, dst_port_q};
    words_d[6] = seq_q;
    words_d[7] = ack_q;
    words_d[8] = {TcpOffset, 4'h0, flags_q, TcpWindow};
    words_d[9] = {tcp_csum, 16'h0000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q <= '0;
      dst_addr_q <= '0;
      src_port_q <= '0;
      dst_port_q <= '0;
      ack_q      <= '0;
      flags_q    <= '0;
      use_ann_q  <= 1'b0;
      ident_q    <= '0;
      seq_q      <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          CfgSrcAddr:  src_addr_q <= cfg_i.data;
          CfgDstAddr:  dst_addr_q <= cfg_i.data;
          CfgSrcPort:  src_port_q <= cfg_i.data[15:0];
          CfgDstPort:  dst_port_q <= cfg_i.data[15:0];
          CfgStartSeq: seq_q      <= cfg_i.data;
          CfgAckNum:   ack_q      <= cfg_i.data;
          CfgFlags:    flags_q    <= cfg_i.data[7:0];
          CfgUseAnn:   use_ann_q  <= cfg_i.data[0];
          default: ;
        endcase
      end else if (load) begin
        ident_q <= ident_q + 16'd1;
        seq_q   <= seq_q + 32'(len_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (out_hs) begin
        if (out_last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + WordIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      len_q <= in_i.payload_length;
      ann_q <= in_i.annotated_dest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      words_q <= words_d;
    end else if (out_hs) begin
      for (int i = 0; i < HdrWords - 1; i++) begin
        words_q[i] <= words_q[i+1];
      end
    end
  end

  `ITHB_ASSERT_NXT(a_load_starts, load, busy_q && (cnt_q == '0), "load did not start a header")
  `ITHB_ASSERT_IMP(a_cnt_range, busy_q, cnt_q <= LastIdx, "word counter out of range")
  `ITHB_ASSERT_IMP(a_no_idle_stall, in_valid_q && !busy_q, load, "pending packet not loaded")
  `ITHB_ASSERT_NXT(a_ident_step, load && !cfg_i.valid, ident_q == $past(ident_q) + 16'd1,
    "ident did not advance")
  `ITHB_ASSERT_NXT(a_seq_step, load && !cfg_i.valid, seq_q == $past(seq_q + 32'(len_q)),
    "sequence did not advance by payload length")

endmodule

// ===== test/tb_ipv4_tcp_header_builder.sv =====
module tb_ipv4_tcp_header_builder;
  import ithb_pkg::*;

  localparam int Limit    = 3_000_000;
  localparam int LongHold = 400;
  localparam int NumRegs  = int'(CfgUseAnn) + 1;

  typedef struct packed {
    logic [15:0] plen;
    word_t       ann;
  } pkt_t;

  typedef struct packed {
    word_t                word;
    logic [WordIdxW-1:0]  idx;
    logic                 last;
  } hdr_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ithb_cfg_if cfg_bus ();
  ithb_in_if  pkt_bus ();
  ithb_out_if hdr_bus ();

  ipv4_tcp_header_builder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (pkt_bus),
    .out_o  (hdr_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow registers and running header state
  word_t       src_addr_r, dst_addr_r, seq_r, ack_r;
  logic [15:0] src_port_r, dst_port_r, ident_r;
  logic [7:0]  flags_r;
  logic        use_ann_r;

  pkt_t      pkt_q[$];
  hdr_word_t hdr_q[$];
  pkt_t      next_pkt;
  hdr_word_t want_word;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  logic hold_go    = 1'b0;
  logic holding    = 1'b0;

  function automatic logic [31:0] half_sum(input word_t w);
    return 32'(w[31:16]) + 32'(w[15:0]);
  endfunction

  function automatic logic [15:0] fold_inv(input logic [31:0] a);
    logic [31:0] s;
    s = 32'(a[15:0]) + 32'(a[31:16]);
    s = 32'(s[15:0]) + 32'(s[31:16]);
    return ~s[15:0];
  endfunction

  function automatic void build_header(input logic [15:0] plen, input word_t ann);
    word_t       w[HdrWords];
    word_t       dst;
    logic [31:0] acc;
    logic [15:0] tot;
    hdr_word_t   hw;
    int          i;
    dst  = use_ann_r ? ann : dst_addr_r;
    tot  = plen + HdrBytes;
    w[0] = {IpVerIhl, 8'h00, tot};
    w[1] = {ident_r, 16'h0000};
    w[2] = {IpTtl, IpProtoTcp, 16'h0000};
    w[3] = src_addr_r;
    w[4] = dst;
    acc  = '0;
    for (i = 0; i < 5; i++) acc += half_sum(w[i]);
    w[2][15:0] = fold_inv(acc);
    w[5] = {src_port_r, dst_port_r};
    w[6] = seq_r;
    w[7] = ack_r;
    w[8] = {TcpOffset, 4'h0, flags_r, TcpWindow};
    w[9] = '0;
    acc  = half_sum(src_addr_r) + half_sum(dst) + 32'(IpProtoTcp) + 32'(TcpHdrLen);
    for (i = 5; i < HdrWords; i++) acc += half_sum(w[i]);
    w[9] = {fold_inv(acc), 16'h0000};
    ident_r = ident_r + 16'd1;
    seq_r   = seq_r + 32'(plen);
    for (i = 0; i < HdrWords; i++) begin
      hw.word = w[i];
      hw.idx  = WordIdxW'(i);
      hw.last = (i == HdrWords - 1);
      hdr_q.push_back(hw);
    end
  endfunction

  function automatic int gap_len(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic word_t pick32();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'd65495;
    if (r < 14) return 16'($urandom_range(65496, 65535));
    return 16'($urandom_range(0, 65495));
  endfunction

  task automatic flag_mismatch(input string what, input word_t got, input word_t want);
    err_cnt++;
    if (err_cnt <= 50) $display("mismatch %s: got %08h want %08h", what, got, want);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input word_t val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CfgSrcAddr:  src_addr_r = val;
      CfgDstAddr:  dst_addr_r = val;
      CfgSrcPort:  src_port_r = val[15:0];
      CfgDstPort:  dst_port_r = val[15:0];
      CfgStartSeq: seq_r      = val;
      CfgAckNum:   ack_r      = val;
      CfgFlags:    flags_r    = val[7:0];
      CfgUseAnn:   use_ann_r  = val[0];
      default: ;
    endcase
  endtask

  task automatic push_pkt(input logic [15:0] plen, input word_t ann);
    pkt_t p;
    p.plen = plen;
    p.ann  = ann;
    pkt_q.push_back(p);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pkt_q.size() != 0 || pkt_bus.valid || hdr_q.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  // packet driver; predicts on each accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pkt_bus.valid          <= 1'b0;
      pkt_bus.payload_length <= '0;
      pkt_bus.annotated_dest <= '0;
      send_gap               <= 0;
    end else begin
      if (pkt_bus.valid && pkt_bus.ready) begin
        build_header(pkt_bus.payload_length, pkt_bus.annotated_dest);
      end
      if (!pkt_bus.valid || pkt_bus.ready) begin
        if (send_gap != 0) begin
          pkt_bus.valid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (pkt_q.size() != 0) begin
          next_pkt = pkt_q.pop_front();
          pkt_bus.valid          <= 1'b1;
          pkt_bus.payload_length <= next_pkt.plen;
          pkt_bus.annotated_dest <= next_pkt.ann;
          send_gap               <= gap_len(in_idle_pct);
        end else begin
          pkt_bus.valid <= 1'b0;
        end
      end
    end
  end

  // header word monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hdr_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (hdr_bus.valid && hdr_bus.ready) begin
        if (hdr_q.size() == 0) begin
          flag_mismatch("unexpected word", hdr_bus.header_word, '0);
        end else begin
          want_word = hdr_q.pop_front();
          if (hdr_bus.header_word !== want_word.word)
            flag_mismatch("header_word", hdr_bus.header_word, want_word.word);
          if (hdr_bus.word_index !== want_word.idx)
            flag_mismatch("word_index", word_t'(hdr_bus.word_index), word_t'(want_word.idx));
          if (hdr_bus.last_word !== want_word.last)
            flag_mismatch("last_word", word_t'(hdr_bus.last_word), word_t'(want_word.last));
        end
      end
      if (holding || stall_left != 0) begin
        hdr_bus.ready <= 1'b0;
        if (!holding) stall_left <= stall_left - 1;
      end else begin
        hdr_bus.ready <= 1'b1;
        stall_left    <= gap_len(out_idle_pct);
      end
    end
  end

  initial begin : long_hold
    wait (hold_go);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == Limit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int ph;
    int n;
    rst_ni                 = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
    src_addr_r = '0; dst_addr_r = '0; seq_r = '0; ack_r = '0;
    src_port_r = '0; dst_port_r = '0; ident_r = '0; flags_r = '0; use_ann_r = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values
    @(negedge clk_i);
    push_pkt(16'd0, $urandom());
    push_pkt(16'($urandom_range(0, 65495)), $urandom());
    wait_drained();

    // all ones, sequence wrap, oversized payloads
    write_reg(CfgSrcAddr, '1);
    write_reg(CfgDstAddr, '1);
    write_reg(CfgSrcPort, 32'h0000_FFFF);
    write_reg(CfgDstPort, 32'h0000_FFFF);
    write_reg(CfgStartSeq, 32'hFFFF_FFF0);
    write_reg(CfgAckNum, '1);
    write_reg(CfgFlags, 32'h0000_00FF);
    write_reg(CfgUseAnn, 32'd0);
    in_idle_pct  <= 30;
    out_idle_pct <= 30;
    @(negedge clk_i);
    push_pkt(16'd65495, $urandom());
    push_pkt(16'd0, $urandom());
    push_pkt(16'hFFFF, $urandom());
    push_pkt(16'd65496, $urandom());
    push_pkt(16'd1, $urandom());
    wait_drained();
    write_reg(CfgUseAnn, 32'd1);
    @(negedge clk_i);
    push_pkt(16'd40, '0);
    push_pkt(16'd1460, '1);
    push_pkt(pick_len(), $urandom());
    wait_drained();

    // all zeros with annotation, unknown register index ignored
    write_reg(CfgSrcAddr, '0);
    write_reg(CfgDstAddr, '0);
    write_reg(CfgSrcPort, '0);
    write_reg(CfgDstPort, '0);
    write_reg(CfgStartSeq, '0);
    write_reg(CfgAckNum, '0);
    write_reg(CfgFlags, '0);
    write_reg(CfgIdxW'($urandom_range(NumRegs, 2**CfgIdxW - 1)), $urandom());
    @(negedge clk_i);
    push_pkt(16'd0, '0);
    push_pkt(16'd0, '1);
    push_pkt(16'hFFFF, $urandom());
    wait_drained();

    // random phases
    for (ph = 0; ph < 6; ph++) begin
      write_reg(CfgSrcAddr, pick32());
      write_reg(CfgDstAddr, pick32());
      write_reg(CfgSrcPort, pick32() >> 16);
      write_reg(CfgDstPort, pick32() >> 16);
      write_reg(CfgStartSeq, pick32());
      write_reg(CfgAckNum, pick32());
      write_reg(CfgFlags, pick32() >> 24);
      write_reg(CfgUseAnn, word_t'($urandom_range(1)));
      if ($urandom_range(2) == 0)
        write_reg(CfgIdxW'($urandom_range(NumRegs, 2**CfgIdxW - 1)), $urandom());
      in_idle_pct  <= (ph == 1) ? 0 : $urandom_range(10, 60);
      out_idle_pct <= (ph == 1 || ph == 4) ? 0 : $urandom_range(10, 60);
      @(negedge clk_i);
      if (ph == 2) hold_go <= 1'b1;
      for (n = 0; n < 80; n++) push_pkt(pick_len(), $urandom());
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ithb_pkg.sv
sv/ithb_if.sv
sv/ipv4_tcp_header_builder.sv
test/tb_ipv4_tcp_header_builder.sv
